>>> hdl/teq_pkg.sv
// Shared types and constants of the timestamp event queue.
`timescale 1ns / 1ps
package teq_pkg;

    localparam int QUEUE_DEPTH  = 16;
    localparam int TIME_BITS    = 32;
    localparam int PAYLOAD_BITS = 16;
    localparam int MAX_RESULTS  = 16;

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int RES_W = $clog2(MAX_RESULTS + 1);

    typedef enum logic [1:0] {
        OP_SCHEDULE = 2'd0,
        OP_RUN      = 2'd1,
        OP_CLEAR    = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        KIND_ACK      = 2'd0,
        KIND_DISPATCH = 2'd1,
        KIND_NONE_DUE = 2'd2,
        KIND_CLEARED  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCHED,
        ST_RUN,
        ST_CLEAR
    } state_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_POP
    } cell_cmd_t;

    typedef struct packed {
        cell_cmd_t                 cmd;
        logic [TIME_BITS-1:0]      new_time;
        logic [PAYLOAD_BITS-1:0]   new_payload;
    } cell_ctl_t;

endpackage

>>> hdl/timestamp_event_queue_unit.sv
// Top level of the timestamp event queue: control sequencer, cell row and result register.
//
// Future-event list of a discrete-event simulator, kept sorted in a row of cells.
// Input channel s_*: s_tuser carries the op (schedule, run, clear), s_tdata the
// timestamp or end time and the payload handle. Result channel m_*: m_tuser is
// the result kind, m_tlast marks the final result of an input item.
// An item is taken in the idle state; its first result is written into the output
// register from the op's state once that register is free. Schedule and clear each
// give one result. A run pops one due event per cycle while the receiver does not
// stall, every cell shifting to its left neighbor at once; an insert is a single
// parallel step of the row. The unused op code is dropped without a result.
// One item is worked on at a time; the next is taken once the last result of the
// current one sits in the output register.
// When the receiver stalls, the result register holds and the sequencer waits.
// Reset empties the queue, sets the current time to zero and drops any result.
`timescale 1ns / 1ps
module timestamp_event_queue_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // time_value[31:0], payload[47:32]
    input  logic [1:0]  s_tuser,   // op[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,   // event_time[31:0], event_payload[47:32],
                                   // queue_full[48], now_time[80:49], zero fill
    output logic [1:0]  m_tuser,   // kind[1:0]
    output logic        m_tlast
);

    localparam int TB = teq_pkg::TIME_BITS;
    localparam int PB = teq_pkg::PAYLOAD_BITS;

    teq_pkg::state_t state_reg, state_next;

    logic [TB-1:0]              arg_time_reg, arg_time_next;
    logic [PB-1:0]              arg_payload_reg, arg_payload_next;
    logic [teq_pkg::CNT_W-1:0]  count_reg, count_next;
    logic [teq_pkg::RES_W-1:0]  nres_reg, nres_next;
    logic [TB-1:0]              now_reg, now_next;

    logic                       mvalid_reg, mvalid_next;
    teq_pkg::kind_t             kind_reg, kind_next;
    logic [31:0]                ev_time_reg, ev_time_next;
    logic [15:0]                ev_payload_reg, ev_payload_next;
    logic                       full_reg, full_next;
    logic                       last_reg, last_next;

    teq_pkg::cell_ctl_t         ctl;
    logic [TB-1:0]              head_time;
    logic [PB-1:0]              head_payload;
    logic                       slot_free;
    logic                       head_due;

    teq_chain u_chain (
        .aclk         (aclk),
        .ctl          (ctl),
        .count        (count_reg),
        .head_time    (head_time),
        .head_payload (head_payload)
    );

    assign slot_free = !mvalid_reg || m_tready;
    assign head_due  = (count_reg != '0) && (head_time <= arg_time_reg)
                       && (nres_reg != teq_pkg::RES_W'(teq_pkg::MAX_RESULTS));

    always_comb begin
        state_next       = state_reg;
        arg_time_next    = arg_time_reg;
        arg_payload_next = arg_payload_reg;
        count_next       = count_reg;
        nres_next        = nres_reg;
        now_next         = now_reg;
        mvalid_next      = mvalid_reg && !m_tready;
        kind_next        = kind_reg;
        ev_time_next     = ev_time_reg;
        ev_payload_next  = ev_payload_reg;
        full_next        = full_reg;
        last_next        = last_reg;
        ctl.cmd          = teq_pkg::CELL_HOLD;
        ctl.new_time     = arg_time_reg;
        ctl.new_payload  = arg_payload_reg;
        s_tready         = 1'b0;

        unique case (state_reg)
            teq_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    arg_time_next    = TB'(s_tdata[31:0]);
                    arg_payload_next = PB'(s_tdata[47:32]);
                    nres_next        = '0;
                    unique case (teq_pkg::op_t'(s_tuser))
                        teq_pkg::OP_SCHEDULE: state_next = teq_pkg::ST_SCHED;
                        teq_pkg::OP_RUN:      state_next = teq_pkg::ST_RUN;
                        teq_pkg::OP_CLEAR:    state_next = teq_pkg::ST_CLEAR;
                        default:              state_next = teq_pkg::ST_IDLE;
                    endcase
                end
            end
            teq_pkg::ST_SCHED: begin
                if (slot_free) begin
                    mvalid_next     = 1'b1;
                    kind_next       = teq_pkg::KIND_ACK;
                    ev_time_next    = '0;
                    ev_payload_next = '0;
                    last_next       = 1'b1;
                    if (count_reg == teq_pkg::CNT_W'(teq_pkg::QUEUE_DEPTH)) begin
                        full_next = 1'b1;
                    end else begin
                        full_next  = 1'b0;
                        ctl.cmd    = teq_pkg::CELL_INSERT;
                        count_next = count_reg + 1'b1;
                    end
                    state_next = teq_pkg::ST_IDLE;
                end
            end
            teq_pkg::ST_CLEAR: begin
                if (slot_free) begin
                    mvalid_next     = 1'b1;
                    kind_next       = teq_pkg::KIND_CLEARED;
                    ev_time_next    = '0;
                    ev_payload_next = '0;
                    full_next       = 1'b0;
                    last_next       = 1'b1;
                    count_next      = '0;
                    state_next      = teq_pkg::ST_IDLE;
                end
            end
            teq_pkg::ST_RUN: begin
                if (slot_free) begin
                    full_next = 1'b0;
                    if (head_due) begin
                        ctl.cmd         = teq_pkg::CELL_POP;
                        count_next      = count_reg - 1'b1;
                        nres_next       = nres_reg + 1'b1;
                        now_next        = head_time;
                        mvalid_next     = 1'b1;
                        kind_next       = teq_pkg::KIND_DISPATCH;
                        ev_time_next    = 32'(head_time);
                        ev_payload_next = 16'(head_payload);
                        // last when the queue drains or the result budget is used up
                        last_next = (count_reg == teq_pkg::CNT_W'(1))
                            || (nres_reg == teq_pkg::RES_W'(teq_pkg::MAX_RESULTS - 1));
                        if (last_next) begin
                            state_next = teq_pkg::ST_IDLE;
                        end
                    end else begin
                        state_next = teq_pkg::ST_IDLE;
                        if (nres_reg != teq_pkg::RES_W'(teq_pkg::MAX_RESULTS)) begin
                            // no event due: time advances to the next event past the end time, if one is queued
                            if (count_reg != '0 || nres_reg == '0) begin
                                mvalid_next     = 1'b1;
                                kind_next       = teq_pkg::KIND_NONE_DUE;
                                ev_time_next    = '0;
                                ev_payload_next = '0;
                                last_next       = 1'b1;
                                if (count_reg != '0) begin
                                    now_next = head_time;
                                end
                            end
                        end
                    end
                end
            end
            default: begin
                state_next = teq_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= teq_pkg::ST_IDLE;
            count_reg  <= '0;
            nres_reg   <= '0;
            now_reg    <= '0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            nres_reg   <= nres_next;
            now_reg    <= now_next;
            mvalid_reg <= mvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        arg_time_reg    <= arg_time_next;
        arg_payload_reg <= arg_payload_next;
        kind_reg        <= kind_next;
        ev_time_reg     <= ev_time_next;
        ev_payload_reg  <= ev_payload_next;
        full_reg        <= full_next;
        last_reg        <= last_next;
    end

    assign m_tvalid = mvalid_reg;
    assign m_tuser  = kind_reg;
    assign m_tlast  = last_reg;
    assign m_tdata  = {7'd0, 32'(now_reg), full_reg, ev_payload_reg, ev_time_reg};

`ifndef SYNTH
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= teq_pkg::CNT_W'(teq_pkg::QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_clear_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == teq_pkg::ST_CLEAR && slot_free) |=> count_reg == '0)
        else $error("clear left entries queued");

    a_full_refuse: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == teq_pkg::ST_SCHED && slot_free
         && count_reg == teq_pkg::CNT_W'(teq_pkg::QUEUE_DEPTH))
        |=> ($stable(count_reg) && full_reg))
        else $error("insert into full queue not refused");

    a_dispatch_now: assert property (@(posedge aclk) disable iff (!aresetn)
        (mvalid_reg && kind_reg == teq_pkg::KIND_DISPATCH)
        |-> ev_time_reg == 32'(now_reg))
        else $error("dispatched event time differs from current time");
`endif

endmodule

>>> hdl/teq_cell.sv
// One slot of the sorted queue: keeps, takes the new event, or shifts from a neighbor.
`timescale 1ns / 1ps
module teq_cell (
    input  logic                              aclk,
    input  teq_pkg::cell_ctl_t                ctl,
    input  logic                              occupied,
    input  logic                              prev_lt,
    input  logic [teq_pkg::TIME_BITS-1:0]     prev_time,
    input  logic [teq_pkg::PAYLOAD_BITS-1:0]  prev_payload,
    input  logic [teq_pkg::TIME_BITS-1:0]     next_time,
    input  logic [teq_pkg::PAYLOAD_BITS-1:0]  next_payload,
    output logic [teq_pkg::TIME_BITS-1:0]     cell_time,
    output logic [teq_pkg::PAYLOAD_BITS-1:0]  cell_payload,
    output logic                              cell_lt
);

    logic [teq_pkg::TIME_BITS-1:0]    time_reg, time_next;
    logic [teq_pkg::PAYLOAD_BITS-1:0] payload_reg, payload_next;

    // strictly earlier than the new event: stays in place on insert
    assign cell_lt      = occupied && (time_reg < ctl.new_time);
    assign cell_time    = time_reg;
    assign cell_payload = payload_reg;

    always_comb begin
        time_next    = time_reg;
        payload_next = payload_reg;
        unique case (ctl.cmd)
            teq_pkg::CELL_INSERT: begin
                if (!cell_lt) begin
                    if (prev_lt) begin
                        time_next    = ctl.new_time;
                        payload_next = ctl.new_payload;
                    end else begin
                        time_next    = prev_time;
                        payload_next = prev_payload;
                    end
                end
            end
            teq_pkg::CELL_POP: begin
                time_next    = next_time;
                payload_next = next_payload;
            end
            teq_pkg::CELL_HOLD: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        time_reg    <= time_next;
        payload_reg <= payload_next;
    end

endmodule

>>> hdl/teq_chain.sv
// Row of queue cells, earliest event in cell 0.
`timescale 1ns / 1ps
module teq_chain (
    input  logic                              aclk,
    input  teq_pkg::cell_ctl_t                ctl,
    input  logic [teq_pkg::CNT_W-1:0]         count,
    output logic [teq_pkg::TIME_BITS-1:0]     head_time,
    output logic [teq_pkg::PAYLOAD_BITS-1:0]  head_payload
);

    logic [teq_pkg::TIME_BITS-1:0]    times    [teq_pkg::QUEUE_DEPTH];
    logic [teq_pkg::PAYLOAD_BITS-1:0] payloads [teq_pkg::QUEUE_DEPTH];
    logic                             lts      [teq_pkg::QUEUE_DEPTH];

    genvar i;
    generate
        for (i = 0; i < teq_pkg::QUEUE_DEPTH; i++) begin : g_cell
            logic                              occ;
            logic                              p_lt;
            logic [teq_pkg::TIME_BITS-1:0]     p_time, n_time;
            logic [teq_pkg::PAYLOAD_BITS-1:0]  p_payload, n_payload;

            assign occ = (teq_pkg::CNT_W'(i) < count);

            if (i == 0) begin : g_first
                // the first cell has nothing earlier: it takes the new event unless its own is earlier
                assign p_lt      = 1'b1;
                assign p_time    = '0;
                assign p_payload = '0;
            end else begin : g_mid
                assign p_lt      = lts[i-1];
                assign p_time    = times[i-1];
                assign p_payload = payloads[i-1];
            end

            if (i == teq_pkg::QUEUE_DEPTH - 1) begin : g_last
                assign n_time    = '0;
                assign n_payload = '0;
            end else begin : g_inner
                assign n_time    = times[i+1];
                assign n_payload = payloads[i+1];
            end

            teq_cell u_cell (
                .aclk         (aclk),
                .ctl          (ctl),
                .occupied     (occ),
                .prev_lt      (p_lt),
                .prev_time    (p_time),
                .prev_payload (p_payload),
                .next_time    (n_time),
                .next_payload (n_payload),
                .cell_time    (times[i]),
                .cell_payload (payloads[i]),
                .cell_lt      (lts[i])
            );
        end
    endgenerate

    assign head_time    = times[0];
    assign head_payload = payloads[0];

endmodule

>>> tb/sv/timestamp_event_queue_unit_test.sv
// Self-checking testbench for the timestamp event queue: directed table, then random traffic.
`timescale 1ns / 1ps
module timestamp_event_queue_unit_test;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 420;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 40;

    typedef struct packed {
        teq_pkg::kind_t                   kind;
        logic [teq_pkg::TIME_BITS-1:0]    ev_time;
        logic [teq_pkg::PAYLOAD_BITS-1:0] ev_payload;
        logic                             full;
        logic [teq_pkg::TIME_BITS-1:0]    now_t;
        logic                             last;
    } result_t;

    typedef struct {
        logic [1:0]                       op;
        logic [teq_pkg::TIME_BITS-1:0]    tv;
        logic [teq_pkg::PAYLOAD_BITS-1:0] pay;
        bit                               typed;
        result_t                          fixed;
    } stim_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;   // time_value[31:0], payload[47:32]
    logic [1:0]  s_tuser;   // op[1:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [87:0] m_tdata;   // event_time[31:0], event_payload[47:32],
                            // queue_full[48], now_time[80:49], zero fill
    logic [1:0]  m_tuser;   // kind[1:0]
    logic        m_tlast;

    timestamp_event_queue_unit uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // Shadow copy of the event list
    logic [teq_pkg::TIME_BITS-1:0]    list_time [teq_pkg::QUEUE_DEPTH];
    logic [teq_pkg::PAYLOAD_BITS-1:0] list_payload [teq_pkg::QUEUE_DEPTH];
    int                               list_count = 0;
    logic [teq_pkg::TIME_BITS-1:0]    list_now = '0;

    result_t   awaited_results[$];
    stim_row_t stim_table[$];
    int        error_count = 0;
    int        accepted_items;
    int        burst_left;
    int        cycle_count;
    bit        drv_typed;
    result_t   drv_fixed;
    bit        stall_request;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic result_t make_result(teq_pkg::kind_t kind,
                                            logic [teq_pkg::TIME_BITS-1:0] t,
                                            logic [teq_pkg::PAYLOAD_BITS-1:0] p,
                                            logic full,
                                            logic [teq_pkg::TIME_BITS-1:0] now);
        result_t r;
        r.kind       = kind;
        r.ev_time    = t;
        r.ev_payload = p;
        r.full       = full;
        r.now_t      = now;
        r.last       = 1'b0;
        return r;
    endfunction

    // Applies one item to the shadow list and queues the results it causes
    task automatic advance_event_list(input logic [1:0] op,
                                      input logic [teq_pkg::TIME_BITS-1:0] tv,
                                      input logic [teq_pkg::PAYLOAD_BITS-1:0] pay);
        result_t                          res[$];
        int                               pos;
        int                               i;
        logic [teq_pkg::TIME_BITS-1:0]    t;
        logic [teq_pkg::PAYLOAD_BITS-1:0] p;
        case (op)
            teq_pkg::OP_SCHEDULE: begin
                if (list_count >= teq_pkg::QUEUE_DEPTH) begin
                    res.push_back(make_result(teq_pkg::KIND_ACK, '0, '0, 1'b1, list_now));
                end else begin
                    pos = 0;
                    while (pos < list_count && list_time[pos] < tv) pos++;
                    for (i = list_count; i > pos; i--) begin
                        list_time[i]    = list_time[i-1];
                        list_payload[i] = list_payload[i-1];
                    end
                    list_time[pos]    = tv;
                    list_payload[pos] = pay;
                    list_count++;
                    res.push_back(make_result(teq_pkg::KIND_ACK, '0, '0, 1'b0, list_now));
                end
            end
            teq_pkg::OP_RUN: begin
                while (list_count > 0 && list_time[0] <= tv
                       && res.size() < teq_pkg::MAX_RESULTS) begin
                    t = list_time[0];
                    p = list_payload[0];
                    for (i = 1; i < list_count; i++) begin
                        list_time[i-1]    = list_time[i];
                        list_payload[i-1] = list_payload[i];
                    end
                    list_count--;
                    list_now = t;
                    res.push_back(make_result(teq_pkg::KIND_DISPATCH, t, p, 1'b0, list_now));
                end
                if (res.size() < teq_pkg::MAX_RESULTS) begin
                    // first event past the end time still moves the clock
                    if (list_count > 0 && list_time[0] > tv) begin
                        list_now = list_time[0];
                        res.push_back(make_result(teq_pkg::KIND_NONE_DUE, '0, '0, 1'b0,
                                                  list_now));
                    end else if (res.size() == 0) begin
                        res.push_back(make_result(teq_pkg::KIND_NONE_DUE, '0, '0, 1'b0,
                                                  list_now));
                    end
                end
            end
            teq_pkg::OP_CLEAR: begin
                list_count = 0;
                res.push_back(make_result(teq_pkg::KIND_CLEARED, '0, '0, 1'b0, list_now));
            end
            default: ;
        endcase
        if (res.size() > 0) res[res.size()-1].last = 1'b1;
        foreach (res[k]) awaited_results.push_back(res[k]);
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            $display("%0t: mismatch on %s: expected %0h, got %0h", $time, name, want, got);
            error_count++;
        end
    endtask

    always @(posedge aclk) begin : port_monitor
        result_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (awaited_results.size() == 0) begin
                    $display("%0t: unexpected result: kind %0h, tdata %0h, tlast %0b",
                             $time, m_tuser, m_tdata, m_tlast);
                    error_count++;
                end else begin
                    want = awaited_results.pop_front();
                    check_field("kind", want.kind, m_tuser);
                    check_field("event_time", want.ev_time, m_tdata[31:0]);
                    check_field("event_payload", want.ev_payload, m_tdata[47:32]);
                    check_field("queue_full", want.full, m_tdata[48]);
                    check_field("now_time", want.now_t, m_tdata[80:49]);
                    check_field("tdata fill", '0, m_tdata[87:81]);
                    check_field("last", want.last, m_tlast);
                end
            end
            if (s_tvalid && s_tready) begin
                advance_event_list(s_tuser, s_tdata[31:0], s_tdata[47:32]);
                // a hand-written expectation replaces the single predicted one
                if (drv_typed) begin
                    void'(awaited_results.pop_back());
                    awaited_results.push_back(drv_fixed);
                end
            end
        end
    end

    // Receiver: stall pattern changes every so often; a long hold-off on request
    initial begin : result_sink
        int hold_left;
        int mode;
        int mode_left;
        int phase;
        bit hold_taken;
        hold_left  = 0;
        mode       = 0;
        mode_left  = 0;
        phase      = 0;
        hold_taken = 1'b0;
        m_tready   = 1'b0;
        forever begin
            @(negedge aclk);
            if (stall_request && !hold_taken) begin
                hold_taken = 1'b1;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(20, 120);
                end
                mode_left--;
                phase++;
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= $urandom_range(0, 1);
                    2: m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= (phase % 3 == 0);
                endcase
            end
        end
    end

    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Called at a falling edge; returns at the falling edge after the item is taken
    task automatic offer(input logic [1:0] op, input logic [teq_pkg::TIME_BITS-1:0] tv,
                         input logic [teq_pkg::PAYLOAD_BITS-1:0] pay, input bit typed,
                         input result_t fixed);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        burst_left--;
        drv_typed = typed;
        drv_fixed = fixed;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {pay, tv};
        do @(posedge aclk); while (!s_tready);
        if (op != OP_UNUSED) accepted_items++;
        @(negedge aclk);
    endtask

    task automatic add_row(input logic [1:0] op, input logic [teq_pkg::TIME_BITS-1:0] tv,
                           input logic [teq_pkg::PAYLOAD_BITS-1:0] pay,
                           input bit typed = 1'b0,
                           input teq_pkg::kind_t kind = teq_pkg::KIND_ACK,
                           input logic full = 1'b0,
                           input logic [teq_pkg::TIME_BITS-1:0] now = '0);
        stim_row_t row;
        row.op         = op;
        row.tv         = tv;
        row.pay        = pay;
        row.typed      = typed;
        row.fixed      = make_result(kind, '0, '0, full, now);
        row.fixed.last = 1'b1;
        stim_table.push_back(row);
    endtask

    function automatic logic [teq_pkg::TIME_BITS-1:0] pick_time();
        case ($urandom_range(0, 7))
            0: return $urandom();
            1: return $urandom_range(0, 15);
            2: return 32'hFFFF_FFFF - $urandom_range(0, 15);
            default: return list_now + $urandom_range(0, 1000);
        endcase
    endfunction

    // End times aimed mostly at queued timestamps so runs split the list
    function automatic logic [teq_pkg::TIME_BITS-1:0] pick_end_time();
        int k;
        if (list_count == 0) return $urandom();
        k = $urandom_range(0, list_count - 1);
        case ($urandom_range(0, 7))
            0: return $urandom();
            1: return '0;
            2: return 32'hFFFF_FFFF;
            3: return list_time[k] - 1;
            default: return list_time[k];
        endcase
    endfunction

    initial begin : stimulus
        int                            directed_items;
        int                            n;
        int                            span;
        bit                            stall_done;
        bit                            pause_done;
        logic [teq_pkg::TIME_BITS-1:0] base;
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = '0;
        stall_request  = 1'b0;
        drv_typed      = 1'b0;
        drv_fixed      = '0;
        accepted_items = 0;
        burst_left     = 0;
        stall_done     = 1'b0;
        pause_done     = 1'b0;

        // empty after reset
        add_row(teq_pkg::OP_RUN, '0, '0, 1'b1, teq_pkg::KIND_NONE_DUE, 1'b0, '0);
        add_row(OP_UNUSED, 32'hDEAD_BEEF, 16'hBEEF);                    // dropped, no result
        add_row(teq_pkg::OP_SCHEDULE, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, teq_pkg::KIND_ACK,
                1'b0, '0);
        add_row(teq_pkg::OP_SCHEDULE, '0, '0, 1'b1, teq_pkg::KIND_ACK, 1'b0, '0);
        add_row(teq_pkg::OP_SCHEDULE, 32'd5, 16'h5555);
        add_row(teq_pkg::OP_SCHEDULE, 32'd5, 16'hAAAA);                 // ties go first
        add_row(teq_pkg::OP_RUN, 32'd4, '0);                            // one due, then next
        add_row(teq_pkg::OP_RUN, 32'd5, '0);
        for (int i = 0; i < 15; i++)
            add_row(teq_pkg::OP_SCHEDULE, (i % 4) * 32'h5555_5555, 16'h1111 * i);
        add_row(teq_pkg::OP_SCHEDULE, 32'h1234_5678, 16'h4321, 1'b1, teq_pkg::KIND_ACK,
                1'b1, 32'hFFFF_FFFF);
        add_row(teq_pkg::OP_RUN, 32'hFFFF_FFFF, '0);                    // full drain in one run
        add_row(teq_pkg::OP_CLEAR, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, teq_pkg::KIND_CLEARED,
                1'b0, 32'hFFFF_FFFF);
        add_row(teq_pkg::OP_RUN, '0, '0);

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (stim_table[r])
            offer(stim_table[r].op, stim_table[r].tv, stim_table[r].pay,
                  stim_table[r].typed, stim_table[r].fixed);
        directed_items = accepted_items;

        // Episodes: a batch of schedules, a few runs, now and then a clear or noise
        while (accepted_items < directed_items + RANDOM_ITEMS) begin
            if (!stall_done && accepted_items >= directed_items + 150) begin
                stall_request = 1'b1;
                stall_done    = 1'b1;
            end
            if (!pause_done && accepted_items >= directed_items + 300) begin
                s_tvalid <= 1'b0;
                do @(negedge aclk); while (awaited_results.size() != 0);
                pause_done = 1'b1;
            end
            n    = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 18) : $urandom_range(1, 6);
            base = pick_time();
            case ($urandom_range(0, 2))
                0: span = 0;
                1: span = 7;
                default: span = 5000;
            endcase
            repeat (n)
                offer(teq_pkg::OP_SCHEDULE, base + $urandom_range(0, span), $urandom(),
                      1'b0, '0);
            repeat ($urandom_range(1, 3))
                offer(teq_pkg::OP_RUN, pick_end_time(), $urandom(), 1'b0, '0);
            case ($urandom_range(0, 9))
                0: offer(teq_pkg::OP_CLEAR, $urandom(), $urandom(), 1'b0, '0);
                1: offer(OP_UNUSED, $urandom(), $urandom(), 1'b0, '0);
                2: offer($urandom_range(0, 3), $urandom(), $urandom(), 1'b0, '0);
                default: ;
            endcase
        end

        s_tvalid <= 1'b0;
        while (awaited_results.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

>>> filelist.f
hdl/teq_pkg.sv
hdl/teq_cell.sv
hdl/teq_chain.sv
hdl/timestamp_event_queue_unit.sv
tb/sv/timestamp_event_queue_unit_test.sv
